[hw/rtl/mfd_pkg.sv]
// Shared types and constants for the match frame decoder.
// Used by the front parser, the back executor and the top level.
`default_nettype none
package mfd_pkg;
    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    localparam logic [1:0] KIND_MATCH = 2'd0;
    localparam logic [1:0] KIND_CLEAN = 2'd1;
    localparam logic [1:0] KIND_TRUNC = 2'd2;
    localparam logic [1:0] KIND_BADIX = 2'd3;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_COUNT  = 2'd1;
    localparam logic [1:0] PH_DELTA  = 2'd2;
    localparam logic [1:0] PH_WEIGHT = 2'd3;

    localparam logic [7:0] MARKER_BYTE = 8'h40;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_MATCH = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  kind;
        logic        indexed;
        logic        last;
        logic [31:0] row_id;
        logic [31:0] value;
        logic [15:0] index;
    } mfd_cmd_t;
endpackage
`default_nettype wire

[hw/rtl/mfd_front.sv]
// Front parser: walks the frame byte stream and issues table loads, matches
// and end reports as commands. Depends on mfd_pkg.
`default_nettype none
module mfd_front import mfd_pkg::*; #(
    parameter int FRAME_SIZE  = 32,
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    input  wire logic [1:0]  in_opcode,
    input  wire logic [7:0]  in_byte,
    input  wire logic [11:0] in_index,
    input  wire logic [31:0] in_weight,
    output logic             cmd_valid,
    output mfd_cmd_t         cmd
);
    localparam logic [7:0] FRAME_PAIRS = 8'(FRAME_SIZE);

    logic [1:0]  phase_reg, phase_next;
    logic [31:0] last_row_reg, last_row_next;
    logic [3:0]  dw_reg, dw_next;
    logic [2:0]  ww_reg, ww_next;
    logic        idx_reg, idx_next;
    logic [7:0]  pairs_reg, pairs_next;
    logic [2:0]  pos_reg, pos_next;
    logic [31:0] dacc_reg, dacc_next;
    logic [31:0] wacc_reg, wacc_next;
    logic [31:0] wfull;
    logic [31:0] dfull;

    always_comb begin
        dfull = dacc_reg;
        wfull = wacc_reg;
        if (pos_reg < 3'd4) begin
            dfull = dacc_reg | (32'(in_byte) << {pos_reg[1:0], 3'b000});
            wfull = wacc_reg | (32'(in_byte) << {pos_reg[1:0], 3'b000});
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        last_row_next = last_row_reg;
        dw_next       = dw_reg;
        ww_next       = ww_reg;
        idx_next      = idx_reg;
        pairs_next    = pairs_reg;
        pos_next      = pos_reg;
        dacc_next     = dacc_reg;
        wacc_next     = wacc_reg;
        cmd_valid     = 1'b0;
        cmd           = '0;
        if (in_valid) begin
            if (in_opcode == OP_LOAD) begin
                if (32'(in_index) < 32'(TABLE_DEPTH)) begin
                    cmd_valid = 1'b1;
                end
                cmd.cmd   = CMD_LOAD;
                cmd.index = 16'(in_index);
                cmd.value = in_weight;
            end else if (in_opcode == OP_END) begin
                cmd_valid     = 1'b1;
                cmd.cmd       = CMD_END;
                cmd.kind      = (phase_reg == PH_HEADER) ? KIND_CLEAN : KIND_TRUNC;
                phase_next    = PH_HEADER;
                last_row_next = '1;
                dw_next       = '0;
                ww_next       = '0;
                idx_next      = 1'b0;
                pairs_next    = '0;
                pos_next      = '0;
                dacc_next     = '0;
                wacc_next     = '0;
            end else if (in_opcode == OP_DATA) begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        if (in_byte == MARKER_BYTE) begin
                            last_row_next = '1;
                        end else begin
                            dw_next  = 4'd1 + 4'(in_byte[2:0]);
                            ww_next  = 3'd1 + 3'(in_byte[4:3]);
                            idx_next = in_byte[5] & ~in_byte[7];
                            if (in_byte[7]) begin
                                phase_next = PH_COUNT;
                            end else begin
                                pairs_next = FRAME_PAIRS;
                                phase_next = PH_DELTA;
                                pos_next   = '0;
                                dacc_next  = '0;
                                wacc_next  = '0;
                            end
                        end
                    end
                    PH_COUNT: begin
                        pairs_next = in_byte;
                        if (in_byte == 8'd0) begin
                            phase_next = PH_HEADER;
                        end else begin
                            phase_next = PH_DELTA;
                            pos_next   = '0;
                            dacc_next  = '0;
                            wacc_next  = '0;
                        end
                    end
                    PH_DELTA: begin
                        dacc_next = dfull;
                        if ({1'b0, pos_reg} + 4'd1 >= dw_reg) begin
                            last_row_next = last_row_reg + dfull + 32'd1;
                            phase_next    = PH_WEIGHT;
                            pos_next      = '0;
                            wacc_next     = '0;
                        end else begin
                            pos_next = pos_reg + 3'd1;
                        end
                    end
                    PH_WEIGHT: begin
                        wacc_next = wfull;
                        if (pos_reg + 3'd1 < ww_reg) begin
                            pos_next = pos_reg + 3'd1;
                        end else begin
                            cmd_valid  = 1'b1;
                            cmd.cmd    = CMD_MATCH;
                            cmd.row_id = last_row_reg;
                            cmd.value  = wfull;
                            cmd.last   = (pairs_reg == 8'd1);
                            cmd.index  = 16'(wfull);
                            cmd.indexed = idx_reg;
                            cmd.kind   = KIND_MATCH;
                            if (idx_reg && wfull >= 32'(TABLE_DEPTH)) begin
                                cmd.kind = KIND_BADIX;
                            end
                            pairs_next = pairs_reg - 8'd1;
                            if (pairs_reg == 8'd1) begin
                                phase_next = PH_HEADER;
                            end else begin
                                phase_next = PH_DELTA;
                                pos_next   = '0;
                                dacc_next  = '0;
                                wacc_next  = '0;
                            end
                        end
                    end
                    default: phase_next = PH_HEADER;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            last_row_reg <= '1;
            dw_reg       <= '0;
            ww_reg       <= '0;
            idx_reg      <= 1'b0;
            pairs_reg    <= '0;
            pos_reg      <= '0;
            dacc_reg     <= '0;
            wacc_reg     <= '0;
        end else begin
            phase_reg    <= phase_next;
            last_row_reg <= last_row_next;
            dw_reg       <= dw_next;
            ww_reg       <= ww_next;
            idx_reg      <= idx_next;
            pairs_reg    <= pairs_next;
            pos_reg      <= pos_next;
            dacc_reg     <= dacc_next;
            wacc_reg     <= wacc_next;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/mfd_queue.sv]
// Short command queue between the front parser and the back executor.
// Depends on mfd_pkg for the command type.
`default_nettype none
module mfd_queue import mfd_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     wr_en,
    input  wire mfd_cmd_t wr_data,
    output logic          slots_free,
    input  wire logic     rd_en,
    output logic          rd_valid,
    output mfd_cmd_t      rd_data
);
    mfd_cmd_t   mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign rd_valid   = (cnt_reg != 3'd0);
    assign rd_data    = mem_reg[rp_reg];
    assign slots_free = (cnt_reg <= 3'd2);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (rd_en) begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 3'(wr_en) - 3'(rd_en);
        end
    end
endmodule
`default_nettype wire

[hw/rtl/mfd_back.sv]
// Back executor: owns the weight table, performs loads and lookups, and
// holds results in a two-stage pipeline with output register. Uses mfd_pkg.
`default_nettype none
module mfd_back import mfd_pkg::*; #(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     cmd_valid,
    input  wire mfd_cmd_t cmd,
    output logic          cmd_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output logic [1:0]    out_kind,
    output logic [31:0]   out_row_id,
    output logic [31:0]   out_weight,
    output logic          out_last
);
    localparam int AW = $clog2(TABLE_DEPTH);

    logic [31:0] table_mem [TABLE_DEPTH];
    logic [31:0] rd_reg;
    logic        s1_valid_reg;
    logic        s1_look_reg;
    logic [1:0]  s1_kind_reg;
    logic [31:0] s1_row_reg, s1_val_reg;
    logic        s1_last_reg;
    logic        o_valid_reg;
    logic [1:0]  o_kind_reg;
    logic [31:0] o_row_reg, o_w_reg;
    logic        o_last_reg;
    logic        s1_adv, take, is_res;

    assign s1_adv    = !o_valid_reg || out_ready;
    assign cmd_ready = !s1_valid_reg || s1_adv;
    assign take      = cmd_valid && cmd_ready;
    assign is_res    = cmd.cmd != CMD_LOAD;

    always_ff @(posedge aclk) begin
        if (take && cmd.cmd == CMD_LOAD) begin
            table_mem[cmd.index[AW-1:0]] <= cmd.value;
        end
        if (take) begin
            rd_reg <= table_mem[cmd.index[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            s1_look_reg <= cmd.indexed && cmd.kind == KIND_MATCH;
            s1_kind_reg <= (cmd.cmd == CMD_END) ? cmd.kind : cmd.kind;
            s1_row_reg  <= (cmd.cmd == CMD_END) ? 32'd0 : cmd.row_id;
            s1_val_reg  <= (cmd.cmd == CMD_END || cmd.kind == KIND_BADIX) ? 32'd0
                                                                           : cmd.value;
            s1_last_reg <= (cmd.cmd == CMD_END) ? 1'b0 : cmd.last;
        end
        if (s1_valid_reg && s1_adv) begin
            o_kind_reg <= s1_kind_reg;
            o_row_reg  <= s1_row_reg;
            o_w_reg    <= s1_look_reg ? rd_reg : s1_val_reg;
            o_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else begin
            if (cmd_ready) begin
                s1_valid_reg <= take && is_res;
            end
            if (s1_adv) begin
                o_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_kind   = o_kind_reg;
    assign out_row_id = o_row_reg;
    assign out_weight = o_w_reg;
    assign out_last   = o_last_reg;
endmodule
`default_nettype wire

[hw/rtl/match_frame_decoder.sv]
// Top level of the match frame decoder: front parser, command queue and
// back executor with the weight table. Depends on mfd_pkg and the mfd_ modules.
`default_nettype none
// The decoder takes one item per cycle while input ready is high. Data bytes
// only update the front parser registers; a finished pair, an in-range table
// load or an end report becomes a command in a four-entry queue, and the back
// part writes or reads the weight table memory and delivers a result through a
// stage-one register and an output register. Input ready drops only when the
// queue is nearly full because the result side is stalled.
module match_frame_decoder import mfd_pkg::*; #(
    parameter int FRAME_SIZE  = 32,
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // data_byte [7:0], table_index [19:8], table_weight [51:20]
    input  wire logic [55:0] s_tdata,
    // opcode [1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // row_id [31:0], weight [63:32]
    output logic [63:0]      m_tdata,
    // kind [1:0]
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);
    logic      fc_valid, q_free, q_valid, q_ready;
    mfd_cmd_t  fc, qc;
    logic      acc;
    logic [31:0] row_out, weight_out;

    assign s_tready = q_free;
    assign acc      = s_tvalid && s_tready;
    assign m_tdata  = {weight_out, row_out};

    mfd_front #(.FRAME_SIZE(FRAME_SIZE), .TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(acc), .in_opcode(s_tuser),
        .in_byte(s_tdata[7:0]), .in_index(s_tdata[19:8]),
        .in_weight(s_tdata[51:20]), .cmd_valid(fc_valid), .cmd(fc)
    );

    mfd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_en(fc_valid), .wr_data(fc),
        .slots_free(q_free), .rd_en(q_valid && q_ready), .rd_valid(q_valid),
        .rd_data(qc)
    );

    mfd_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cmd_valid(q_valid), .cmd(qc),
        .cmd_ready(q_ready), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_kind(m_tuser), .out_row_id(row_out),
        .out_weight(weight_out), .out_last(m_tlast)
    );

    a_end_no_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_CLEAN || m_tuser == KIND_TRUNC) |-> !m_tlast)
        else $error("end report carries frame_last");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("waiting result changed");
    a_badix_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_BADIX |-> m_tdata[63:32] == 32'd0)
        else $error("bad index result with nonzero weight");
endmodule
`default_nettype wire
